@@ rtl/pll_angle_speed_tracker_top_assert.svh @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef PLL_ANGLE_SPEED_TRACKER_TOP_ASSERT_SVH
`define PLL_ANGLE_SPEED_TRACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/past_pkg.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: package
// Control word layout, microprogram and shared constants.
// ----------------------------------------------------------------------------
package past_pkg;

    localparam int ACC_BITS  = 32;
    localparam int PROD_BITS = 64;
    localparam int STEP_BITS = 4;
    localparam int CFG_BITS  = 2;
    localparam int VSUM_BITS = 42;
    localparam int VCOR_BITS = 40;

    typedef logic [CFG_BITS-1:0]  cfg_idx_t;
    typedef logic [STEP_BITS-1:0] step_t;

    localparam cfg_idx_t REG_TICK_PERIOD = 2'd0;
    localparam cfg_idx_t REG_PROP_GAIN   = 2'd1;
    localparam cfg_idx_t REG_INTEG_GAIN  = 2'd2;

    localparam logic [ACC_BITS-1:0]  TICK_PERIOD_RESET = 32'd214748;
    localparam logic [ACC_BITS-1:0]  VEL_MAX           = 32'h7FFF_FFFF;
    localparam logic [ACC_BITS-1:0]  VEL_MIN           = 32'h8000_0000;
    localparam logic [47:0]          RND_PRED          = 48'h0000_0000_8000;
    localparam logic [PROD_BITS-1:0] RND_POS           = 64'h0000_8000_0000_0000;
    localparam logic [PROD_BITS-1:0] RND_VEL           = 64'h0080_0000_0000_0000;

    typedef enum logic [1:0] {MA_VMAG, MA_EMAG, MA_TICK} mul_a_t;
    typedef enum logic [2:0] {MB_TICK, MB_PROP, MB_INTEG, MB_G_LO, MB_G_HI} mul_b_t;
    typedef enum logic [2:0] {ALU_NOP, ALU_PRED, ALU_ERR, ALU_LO, ALU_POS, ALU_VEL} alu_op_t;
    typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_t;
    typedef enum logic {BR_NEXT, BR_START} branch_t;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t alu;
        logic    rnd_vel;
        logic    g_load;
        logic    in_rdy;
        logic    out_load;
        wait_t   wait_on;
        branch_t br;
    } ctrl_t;

    localparam ctrl_t CW_NOP = '{
        mul_a: MA_TICK, mul_b: MB_TICK, alu: ALU_NOP, rnd_vel: 1'b0, g_load: 1'b0,
        in_rdy: 1'b0, out_load: 1'b0, wait_on: WAIT_NONE, br: BR_NEXT
    };

    localparam step_t STEP_IDLE = 4'd0;

    function automatic ctrl_t program_word(input step_t step);
        ctrl_t w;
        w = CW_NOP;
        unique case (step)
            4'd0: begin
                w.in_rdy  = 1'b1;
                w.wait_on = WAIT_IN;
                w.mul_a   = MA_VMAG;
                w.mul_b   = MB_TICK;
            end
            4'd1: begin
                w.alu   = ALU_PRED;
                w.mul_b = MB_PROP;
            end
            4'd2: begin
                w.alu    = ALU_ERR;
                w.g_load = 1'b1;
            end
            4'd3: begin
                w.mul_a = MA_EMAG;
                w.mul_b = MB_G_LO;
            end
            4'd4: begin
                w.alu   = ALU_LO;
                w.mul_a = MA_EMAG;
                w.mul_b = MB_G_HI;
            end
            4'd5: begin
                w.alu   = ALU_POS;
                w.mul_b = MB_INTEG;
            end
            4'd6: begin
                w.g_load = 1'b1;
            end
            4'd7: begin
                w.mul_a = MA_EMAG;
                w.mul_b = MB_G_LO;
            end
            4'd8: begin
                w.alu     = ALU_LO;
                w.rnd_vel = 1'b1;
                w.mul_a   = MA_EMAG;
                w.mul_b   = MB_G_HI;
            end
            4'd9: begin
                w.alu = ALU_VEL;
            end
            4'd10: begin
                w.out_load = 1'b1;
                w.wait_on  = WAIT_OUT;
                w.br       = BR_START;
            end
            default: begin
                w.br = BR_START;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/past_sequencer.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: sequencer
// Step counter over the microprogram, with waits on the input and output.
// ----------------------------------------------------------------------------
module past_sequencer
    import past_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  out_free,
    output ctrl_t cw
);

    step_t step_reg;
    step_t step_next;

    assign cw = program_word(step_reg);

    always_comb begin
        priority if (cw.wait_on == WAIT_IN && !s_valid) begin
            step_next = step_reg;
        end else if (cw.wait_on == WAIT_OUT && !out_free) begin
            step_next = step_reg;
        end else if (cw.br == BR_START) begin
            step_next = STEP_IDLE;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/past_datapath.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: datapath
// Shared multiplier, accumulators, configuration and output registers.
// ----------------------------------------------------------------------------
module past_datapath
    import past_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_t                 cw,
    input  logic                  s_valid,
    input  logic [ANGLE_BITS-1:0] s_measured_angle,
    input  logic                  m_ready,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [ACC_BITS-1:0]   cfg_wr_data,
    output logic                  out_free,
    output logic                  m_valid,
    output logic [ANGLE_BITS-1:0] m_angle_estimate,
    output logic signed [ACC_BITS-1:0] m_speed_estimate
);

    localparam int FRAC_BITS = ACC_BITS - ANGLE_BITS;

    logic [ACC_BITS-1:0]   tick_reg, tick_next;
    logic [ACC_BITS-1:0]   prop_reg, prop_next;
    logic [ACC_BITS-1:0]   integ_reg, integ_next;
    logic [ACC_BITS-1:0]   pos_reg, pos_next;
    logic [ACC_BITS-1:0]   vel_reg, vel_next;
    logic [ANGLE_BITS-1:0] meas_reg, meas_next;
    logic [ACC_BITS-1:0]   emag_reg, emag_next;
    logic                  eneg_reg, eneg_next;
    logic [ACC_BITS-1:0]   lo_reg, lo_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [PROD_BITS-1:0]  g_reg, g_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ANGLE_BITS-1:0] angle_reg, angle_next;
    logic [ACC_BITS-1:0]   speed_reg, speed_next;

    logic [ACC_BITS-1:0]   vmag;
    logic [ACC_BITS-1:0]   mul_a_val;
    logic [ACC_BITS-1:0]   mul_b_val;
    logic [47:0]           pred_sum;
    logic [ACC_BITS-1:0]   pred_step;
    logic [ACC_BITS-1:0]   diff;
    logic [PROD_BITS-1:0]  lo_sum;
    logic [PROD_BITS-1:0]  hi_sum;
    logic [ACC_BITS-1:0]   pos_corr;
    logic [VCOR_BITS-1:0]  vel_corr;
    logic [VSUM_BITS-1:0]  vel_ext;
    logic [VSUM_BITS-1:0]  vel_sum;
    logic [ACC_BITS-1:0]   vel_sat;

    assign out_free         = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_angle_estimate = angle_reg;
    assign m_speed_estimate = speed_reg;

    assign vmag = vel_reg[ACC_BITS-1] ? (32'd0 - vel_reg) : vel_reg;

    always_comb begin
        unique case (cw.mul_a)
            MA_VMAG: mul_a_val = vmag;
            MA_EMAG: mul_a_val = emag_reg;
            MA_TICK: mul_a_val = tick_reg;
            default: mul_a_val = tick_reg;
        endcase
        unique case (cw.mul_b)
            MB_TICK:  mul_b_val = tick_reg;
            MB_PROP:  mul_b_val = prop_reg;
            MB_INTEG: mul_b_val = integ_reg;
            MB_G_LO:  mul_b_val = g_reg[ACC_BITS-1:0];
            MB_G_HI:  mul_b_val = g_reg[PROD_BITS-1:ACC_BITS];
            default:  mul_b_val = tick_reg;
        endcase
    end

    assign pred_sum  = prod_reg[47:0] + RND_PRED;
    assign pred_step = pred_sum[47:16];
    assign diff      = {meas_reg, {FRAC_BITS{1'b0}}} - pos_reg;
    assign lo_sum    = prod_reg + (cw.rnd_vel ? RND_VEL : RND_POS);
    assign hi_sum    = prod_reg + {32'd0, lo_reg};
    assign pos_corr  = hi_sum[47:16];
    assign vel_corr  = hi_sum[63:24];
    assign vel_ext   = {{(VSUM_BITS-ACC_BITS){vel_reg[ACC_BITS-1]}}, vel_reg};
    assign vel_sum   = eneg_reg ? (vel_ext - {2'b00, vel_corr})
                                : (vel_ext + {2'b00, vel_corr});

    always_comb begin
        if (vel_sum[VSUM_BITS-1:ACC_BITS-1] == {(VSUM_BITS-ACC_BITS+1){vel_sum[VSUM_BITS-1]}})
        begin
            vel_sat = vel_sum[ACC_BITS-1:0];
        end else begin
            vel_sat = vel_sum[VSUM_BITS-1] ? VEL_MIN : VEL_MAX;
        end
    end

    always_comb begin
        tick_next    = tick_reg;
        prop_next    = prop_reg;
        integ_next   = integ_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        meas_next    = meas_reg;
        emag_next    = emag_reg;
        eneg_next    = eneg_reg;
        lo_next      = lo_reg;
        g_next       = g_reg;
        m_valid_next = m_valid_reg;
        angle_next   = angle_reg;
        speed_next   = speed_reg;

        prod_next = PROD_BITS'(mul_a_val) * PROD_BITS'(mul_b_val);

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TICK_PERIOD: tick_next  = cfg_wr_data;
                REG_PROP_GAIN:   prop_next  = cfg_wr_data;
                REG_INTEG_GAIN:  integ_next = cfg_wr_data;
                default: ;
            endcase
        end

        if (cw.in_rdy && s_valid) begin
            meas_next = s_measured_angle;
        end

        if (cw.g_load) begin
            g_next = prod_reg;
        end

        unique case (cw.alu)
            ALU_NOP: ;
            ALU_PRED: begin
                pos_next = pos_reg + (vel_reg[ACC_BITS-1] ? (32'd0 - pred_step) : pred_step);
            end
            ALU_ERR: begin
                eneg_next = diff[ACC_BITS-1];
                emag_next = diff[ACC_BITS-1] ? (32'd0 - diff) : diff;
            end
            ALU_LO: begin
                lo_next = lo_sum[PROD_BITS-1:ACC_BITS];
            end
            ALU_POS: begin
                pos_next = pos_reg + (eneg_reg ? (32'd0 - pos_corr) : pos_corr);
            end
            ALU_VEL: begin
                vel_next = vel_sat;
            end
            default: ;
        endcase

        if (cw.out_load && out_free) begin
            m_valid_next = 1'b1;
            angle_next   = pos_reg[ACC_BITS-1 -: ANGLE_BITS];
            speed_next   = vel_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= TICK_PERIOD_RESET;
            prop_reg    <= '0;
            integ_reg   <= '0;
            pos_reg     <= '0;
            vel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            tick_reg    <= tick_next;
            prop_reg    <= prop_next;
            integ_reg   <= integ_next;
            pos_reg     <= pos_next;
            vel_reg     <= vel_next;
            m_valid_reg <= m_valid_next;
        end
        meas_reg  <= meas_next;
        emag_reg  <= emag_next;
        eneg_reg  <= eneg_next;
        lo_reg    <= lo_next;
        prod_reg  <= prod_next;
        g_reg     <= g_next;
        angle_reg <= angle_next;
        speed_reg <= speed_next;
    end

endmodule

@@ rtl/pll_angle_speed_tracker_top.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: top level
// Tracks encoder angle and speed with a second-order phase-locked loop.
// ----------------------------------------------------------------------------
// Each accepted angle sample runs through an eleven-step microprogram that
// shares one 32 by 32 bit multiplier. The result is loaded into the output
// register at the last step, and a new sample is taken only once the program
// has returned to its first step; the last step waits only while the previous
// result is still held in the output register. The angle estimate is the top
// bits of a 32-bit fraction of a turn and wraps naturally; the speed estimate
// is signed Q16.16 turns per second and saturates.
// ----------------------------------------------------------------------------
module pll_angle_speed_tracker_top
    import past_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ANGLE_BITS-1:0] s_measured_angle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ANGLE_BITS-1:0] m_angle_estimate,
    output logic signed [ACC_BITS-1:0] m_speed_estimate,
    input  logic                  cfg_wr_en,
    input  logic [CFG_BITS-1:0]   cfg_index,
    input  logic [ACC_BITS-1:0]   cfg_wr_data
);

    ctrl_t cw;
    logic  out_free;

    assign s_ready = cw.in_rdy;

    past_sequencer u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .cw       (cw)
    );

    past_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cw               (cw),
        .s_valid          (s_valid),
        .s_measured_angle (s_measured_angle),
        .m_ready          (m_ready),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_angle_estimate (m_angle_estimate),
        .m_speed_estimate (m_speed_estimate)
    );

endmodule

@@ rtl/past_checker.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: port checker
// Watches the top-level ports and is bound to every top-level instance.
// ----------------------------------------------------------------------------
`include "pll_angle_speed_tracker_top_assert.svh"

module past_checker #(
    parameter int ANGLE_BITS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ANGLE_BITS-1:0] m_angle_estimate,
    input logic signed [31:0]    m_speed_estimate
);

    `PAST_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_angle_estimate) && $stable(m_speed_estimate), "result changed before its transfer")
    `PAST_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "second sample taken while the first is in progress")
    `PAST_ASSERT_SAME(a_result_at_start, aclk, aresetn, $rose(m_valid), s_ready, "result appeared before the program returned to its start")
    `PAST_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result appeared one cycle after a sample transfer")

endmodule

bind pll_angle_speed_tracker_top past_checker #(.ANGLE_BITS(ANGLE_BITS)) u_past_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// PLL angle and speed tracker: testbench
// Sends encoder angle samples over a valid/ready channel and checks each
// angle and speed estimate against a cycle-free model of the tracking loop,
// across several gain settings and sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import past_pkg::*;

    localparam int       ANG_W       = 16;
    localparam int       CYCLE_LIMIT = 400000;
    localparam cfg_idx_t REG_SPARE   = 2'd3;

    typedef struct {
        logic [ANG_W-1:0] ang;
        logic [31:0]      spd;
    } track_out_t;

    logic             aclk             = 1'b0;
    logic             aresetn          = 1'b0;
    logic             s_valid          = 1'b0;
    logic             s_ready;
    logic [ANG_W-1:0] s_measured_angle = '0;
    logic             m_valid;
    logic             m_ready          = 1'b0;
    logic [ANG_W-1:0] m_angle_estimate;
    logic signed [31:0] m_speed_estimate;
    logic             cfg_wr_en        = 1'b0;
    cfg_idx_t         cfg_index        = REG_TICK_PERIOD;
    logic [31:0]      cfg_wr_data      = '0;

    logic [31:0] tick_q  = TICK_PERIOD_RESET;
    logic [31:0] kp_q    = '0;
    logic [31:0] ki_q    = '0;
    logic [31:0] pos_est = '0;
    logic [31:0] vel_est = '0;

    logic [ANG_W-1:0] angle_q[$];
    track_out_t       est_q[$];
    int               send_idle_pct = 13;
    int               recv_idle_pct = 55;
    int               err_count     = 0;
    int               cycle_count   = 0;

    pll_angle_speed_tracker_top #(
        .ANGLE_BITS(ANG_W)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_measured_angle(s_measured_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_angle_estimate(m_angle_estimate),
        .m_speed_estimate(m_speed_estimate),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Rounded (mag * gain) / 2^sh, kept to 64-bit wrapping arithmetic throughout.
    function automatic logic [63:0] scaled_round(input logic [31:0] mag,
                                                 input logic [63:0] gain, input int sh);
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        hi_part = {32'd0, mag} * {32'd0, gain[63:32]};
        lo_part = {32'd0, mag} * {32'd0, gain[31:0]} + (64'd1 << (sh - 1));
        return (hi_part + (lo_part >> 32)) >> (sh - 32);
    endfunction

    function automatic void advance_loop(input logic [ANG_W-1:0] meas, output track_out_t res);
        logic [63:0]        vmag;
        logic [63:0]        corr;
        logic [63:0]        gain;
        logic [31:0]        diff;
        logic [31:0]        emag;
        logic               vneg;
        logic               eneg;
        logic signed [63:0] vsum;
        vneg = vel_est[31];
        vmag = {{32{vel_est[31]}}, vel_est};
        if (vneg) vmag = 64'd0 - vmag;
        corr = (vmag * {32'd0, tick_q} + 64'h8000) >> 16;
        if (vneg) corr = 64'd0 - corr;
        pos_est = pos_est + corr[31:0];

        diff = {meas, {(32 - ANG_W){1'b0}}} - pos_est;
        eneg = diff[31];
        emag = eneg ? 32'd0 - diff : diff;

        gain = {32'd0, tick_q} * {32'd0, kp_q};
        corr = scaled_round(emag, gain, 48);
        if (eneg) corr = 64'd0 - corr;
        pos_est = pos_est + corr[31:0];

        gain = {32'd0, tick_q} * {32'd0, ki_q};
        corr = scaled_round(emag, gain, 56);
        if (eneg) corr = 64'd0 - corr;
        vsum = $signed({{32{vel_est[31]}}, vel_est}) + $signed(corr);
        if (vsum > 64'sd2147483647) vel_est = VEL_MAX;
        else if (vsum < -64'sd2147483648) vel_est = VEL_MIN;
        else vel_est = vsum[31:0];

        res.ang = pos_est[31:32-ANG_W];
        res.spd = vel_est;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // Driver: presents queued samples and predicts the result of each transfer.
    always @(posedge aclk) begin
        track_out_t want;
        logic       take;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                advance_loop(s_measured_angle, want);
                est_q.push_back(want);
            end
            if (!s_valid || take) begin
                if (angle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid          <= 1'b1;
                    s_measured_angle <= angle_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        track_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (est_q.size() == 0) begin
                    flag_error("result with none pending, angle", 32'(m_angle_estimate), '0);
                end else begin
                    want = est_q.pop_front();
                    if (m_angle_estimate !== want.ang)
                        flag_error("angle_estimate", 32'(m_angle_estimate), 32'(want.ang));
                    if (m_speed_estimate !== want.spd)
                        flag_error("speed_estimate", m_speed_estimate, want.spd);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_TICK_PERIOD: tick_q = val;
            REG_PROP_GAIN:   kp_q   = val;
            REG_INTEG_GAIN:  ki_q   = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] t, input logic [31:0] kp,
                                 input logic [31:0] ki);
        write_reg(REG_SPARE, $urandom());
        write_reg(REG_TICK_PERIOD, t);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        end_writes();
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (angle_q.size() != 0 || s_valid || est_q.size() != 0);
    endtask

    // Mostly smooth rotations with a little noise so that the loop locks,
    // mixed with random angles and sudden jumps.
    task automatic queue_motion(input int count);
        logic [ANG_W-1:0] ang;
        int               left;
        int               len;
        int               spd;
        int               mag;
        left = count;
        while (left > 0) begin
            len = $urandom_range(8, 40);
            if (len > left) len = left;
            left -= len;
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(3))
                    0: mag = 50;
                    1: mag = 2000;
                    2: mag = 16000;
                    default: mag = 0;
                endcase
                spd = int'($urandom_range(0, 2 * mag)) - mag;
                ang = ANG_W'($urandom());
                repeat (len) begin
                    if ($urandom_range(99) < 5) ang = ANG_W'($urandom());
                    else ang = ang + ANG_W'(spd + int'($urandom_range(0, 8)) - 4);
                    angle_q.push_back(ang);
                end
            end else begin
                repeat (len) angle_q.push_back(ANG_W'($urandom()));
            end
        end
    endtask

    initial begin
        logic [31:0] ph_tick[6];
        logic [31:0] ph_kp[6];
        logic [31:0] ph_ki[6];
        int          ph_items[6];
        ph_tick = '{32'd214748, 32'hFFFF_FFFF, 32'd0, $urandom(), 32'hFFFF_FFFF, 32'd107374};
        ph_kp   = '{32'd131072000, 32'hFFFF_FFFF, $urandom(), $urandom(), 32'd0, 32'd393216000};
        ph_ki   = '{32'd256000000, 32'hFFFF_FFFF, $urandom(), $urandom(), 32'hFFFF_FFFF,
                    32'd2304000000};
        ph_items = '{160, 160, 60, 180, 180, 160};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // The period keeps its reset value for the opening samples.
        write_reg(REG_SPARE, $urandom());
        write_reg(REG_PROP_GAIN, 32'd131072000);
        write_reg(REG_INTEG_GAIN, 32'd256000000);
        end_writes();

        // From a zero estimate the first sample is an error of exactly half a turn.
        angle_q.push_back(16'h8000);
        angle_q.push_back(16'h0000);
        angle_q.push_back(16'hFFFF);
        angle_q.push_back(16'h0001);
        angle_q.push_back(16'h7FFF);
        angle_q.push_back(16'h8001);
        angle_q.push_back(16'h8000);
        angle_q.push_back(16'hAAAA);
        angle_q.push_back(16'h5555);
        for (int i = 1; i <= 10; i++) angle_q.push_back(ANG_W'(i * 16'h0400));
        angle_q.push_back(16'h0000);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            repeat (16) @(posedge aclk);
            if (p < 2) begin
                send_idle_pct = 13;
                recv_idle_pct = 55;
            end else if (p < 4) begin
                send_idle_pct = 55;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_settings(ph_tick[p], ph_kp[p], ph_ki[p]);
            queue_motion(ph_items[p]);
        end

        wait_idle();
        repeat (24) @(posedge aclk);
        if (err_count == 0 && est_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
